FILE: hdl/bscl_pkg.sv
// ----------------------------------------------------------------------------
// bscl_pkg: shared types and constants of the bounded sorted candidate list
// Codes, entry and cell report structs, and the sizes of the cell row and
// its reduction tree.
// ----------------------------------------------------------------------------
package bscl_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int CNT_W      = 9;   // holds 0 .. LIST_DEPTH
  localparam int IDX_W      = 8;   // addresses one cell
  localparam int KEY_W      = 32;
  localparam int ID_W       = 32;
  localparam int CAP_RESET  = 64;

  // reduction tree: GRP_NUM groups of GRP_SIZE cells
  localparam int GRP_SIZE   = 16;
  localparam int GRP_W      = 4;
  localparam int GRP_NUM    = LIST_DEPTH / GRP_SIZE;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_POP    = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_DUP    = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CMP,
    SEQ_TREE,
    SEQ_DONE
  } seq_state_t;

  // operation broadcast to every cell
  typedef struct packed {
    mode_t              mode;
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    node;
    logic [CNT_W-1:0]   sel_idx;  // cursor for pop, index for read
    logic [CNT_W-1:0]   lim;      // cells below this hold live entries
  } op_t;

  // state update broadcast to every cell
  typedef struct packed {
    logic               ins_en;
    logic               pop_en;
    logic [CNT_W-1:0]   pos;
  } cmt_t;

  // one list entry, handed to the right-hand neighbor on a shift
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    node;
    logic               expd;
  } ent_t;

  // per-cell report into the reduction tree
  typedef struct packed {
    logic               dup;
    logic               tail;
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    node;
    logic               cand;
  } rpt_t;

  // reduced report: OR of flags and data, first candidate position
  typedef struct packed {
    logic               dup;
    logic               tail;
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    node;
    logic               found;
    logic [IDX_W-1:0]   first;
  } red_t;

endpackage

FILE: hdl/bscl_if.sv
// ----------------------------------------------------------------------------
// bscl_if: channel interfaces of the bounded sorted candidate list
// Request, result and capacity-write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface bscl_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [bscl_pkg::KEY_W-1:0]    distance;
  logic [bscl_pkg::ID_W-1:0]     node_id;
  logic [bscl_pkg::IDX_W-1:0]    index;

  modport source (output valid, mode, distance, node_id, index, input ready);
  modport sink   (input valid, mode, distance, node_id, index, output ready);
endinterface

interface bscl_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [bscl_pkg::KEY_W-1:0]    out_distance;
  logic [bscl_pkg::ID_W-1:0]     out_id;
  logic                          has_unexpanded;
  logic [bscl_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, status, out_distance, out_id, has_unexpanded,
                  entry_count, input ready);
  modport sink   (input valid, status, out_distance, out_id, has_unexpanded,
                  entry_count, output ready);
endinterface

interface bscl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bscl_pkg::CNT_W-1:0]    capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

FILE: hdl/bscl_cell.sv
// ----------------------------------------------------------------------------
// bscl_cell: one slot of the sorted candidate row
// Holds one entry, compares it against the broadcast operation, and on
// insert either loads the new entry or takes its left neighbor's entry.
// ----------------------------------------------------------------------------
module bscl_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bscl_pkg::IDX_W-1:0]  cell_idx,
  input  bscl_pkg::op_t               op_i,
  input  bscl_pkg::cmt_t              cmt_i,
  input  bscl_pkg::ent_t              left_i,
  output bscl_pkg::ent_t              ent_o,
  output bscl_pkg::rpt_t              rpt_o
);

  logic [bscl_pkg::KEY_W-1:0] dist_r;
  logic [bscl_pkg::ID_W-1:0]  node_r;
  logic                       expd_r;
  bscl_pkg::rpt_t             rpt_nxt;
  bscl_pkg::rpt_t             rpt_r;

  logic [bscl_pkg::CNT_W-1:0] pos_here;
  logic                       live;
  logic                       key_lt;
  logic                       key_gt;
  logic                       sel;

  assign pos_here = {1'b0, cell_idx};
  assign live     = pos_here < op_i.lim;
  assign key_lt   = dist_r < op_i.key;
  assign key_gt   = op_i.key < dist_r;
  assign sel      = live && (pos_here == op_i.sel_idx);

  always_comb begin
    rpt_nxt = '0;
    unique case (op_i.mode)
      bscl_pkg::MODE_INSERT: begin
        rpt_nxt.dup  = live && (node_r == op_i.node);
        rpt_nxt.tail = key_lt && (pos_here + 1'b1 == op_i.lim);
        rpt_nxt.cand = live && key_gt;
      end
      bscl_pkg::MODE_POP: begin
        // next unexpanded entry past the cursor
        rpt_nxt.cand = live && !expd_r && (pos_here > op_i.sel_idx);
        rpt_nxt.key  = sel ? dist_r : '0;
        rpt_nxt.node = sel ? node_r : '0;
      end
      bscl_pkg::MODE_READ: begin
        rpt_nxt.key  = sel ? dist_r : '0;
        rpt_nxt.node = sel ? node_r : '0;
      end
      bscl_pkg::MODE_CLEAR: begin
        rpt_nxt = '0;
      end
      default: begin
        rpt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rpt_r <= rpt_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmt_i.ins_en) begin
      if (pos_here == cmt_i.pos) begin
        dist_r <= op_i.key;
        node_r <= op_i.node;
      end else if (pos_here > cmt_i.pos) begin
        dist_r <= left_i.key;
        node_r <= left_i.node;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expd_r <= 1'b0;
    end else if (cmt_i.ins_en) begin
      if (pos_here == cmt_i.pos) begin
        expd_r <= 1'b0;
      end else if (pos_here > cmt_i.pos) begin
        expd_r <= left_i.expd;
      end
    end else if (cmt_i.pop_en && (pos_here == cmt_i.pos)) begin
      expd_r <= 1'b1;
    end
  end

  assign ent_o = '{key: dist_r, node: node_r, expd: expd_r};
  assign rpt_o = rpt_r;

endmodule

FILE: hdl/bscl_tree.sv
// ----------------------------------------------------------------------------
// bscl_tree: two-level reduction over the cell reports
// ORs flags and selected entry data, and finds the lowest cell that raised
// its candidate flag. The group level is registered.
// ----------------------------------------------------------------------------
module bscl_tree (
  input  logic            clk,
  input  bscl_pkg::rpt_t  rpt_i [bscl_pkg::LIST_DEPTH],
  output bscl_pkg::red_t  red_o
);

  bscl_pkg::red_t grp_nxt [bscl_pkg::GRP_NUM];
  bscl_pkg::red_t grp_r   [bscl_pkg::GRP_NUM];

  always_comb begin
    for (int g = 0; g < bscl_pkg::GRP_NUM; g++) begin
      grp_nxt[g] = '0;
      for (int k = bscl_pkg::GRP_SIZE - 1; k >= 0; k--) begin
        grp_nxt[g].dup  = grp_nxt[g].dup  | rpt_i[g*bscl_pkg::GRP_SIZE + k].dup;
        grp_nxt[g].tail = grp_nxt[g].tail | rpt_i[g*bscl_pkg::GRP_SIZE + k].tail;
        grp_nxt[g].key  = grp_nxt[g].key  | rpt_i[g*bscl_pkg::GRP_SIZE + k].key;
        grp_nxt[g].node = grp_nxt[g].node | rpt_i[g*bscl_pkg::GRP_SIZE + k].node;
        if (rpt_i[g*bscl_pkg::GRP_SIZE + k].cand) begin
          grp_nxt[g].found = 1'b1;
          grp_nxt[g].first = {bscl_pkg::GRP_W'(g), bscl_pkg::GRP_W'(k)};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  always_comb begin
    red_o = '0;
    for (int g = bscl_pkg::GRP_NUM - 1; g >= 0; g--) begin
      red_o.dup  = red_o.dup  | grp_r[g].dup;
      red_o.tail = red_o.tail | grp_r[g].tail;
      red_o.key  = red_o.key  | grp_r[g].key;
      red_o.node = red_o.node | grp_r[g].node;
      if (grp_r[g].found) begin
        red_o.found = 1'b1;
        red_o.first = grp_r[g].first;
      end
    end
  end

endmodule

FILE: hdl/bounded_sorted_candidate_list_core.sv
// ----------------------------------------------------------------------------
// bounded_sorted_candidate_list_core: beam-search candidate list
// Keeps up to capacity (distance, id) entries in ascending order in a row
// of cells, with an expanded mark per entry and a cursor to the nearest
// unexpanded entry.
//
// Usage:
//   in_ch   request word: mode (clear, insert, pop, read), distance,
//           node_id, index. Taken when valid and ready are high.
//   out_ch  one result word per request: status, entry data, whether an
//           unexpanded entry remains, and the entry count.
//   cfg_ch  capacity write, always ready; write it only while idle.
//   A result word follows its accepted request through the
//   cell compare register, the group level of the reduction tree, then the
//   commit that updates cells and loads the output register. One request
//   is in flight at a time, so a new request is taken only after the last commits.
//   The next request is accepted while a result still waits in the output
//   register; if out_ch stalls, the sequencer holds in commit until the
//   register frees.
//   Reset empties the list, clears the cursor and sets capacity to 64.
// ----------------------------------------------------------------------------
module bounded_sorted_candidate_list_core (
  input  logic          clk,
  input  logic          rst_n,
  bscl_in_if.sink       in_ch,
  bscl_out_if.source    out_ch,
  bscl_cfg_if.sink      cfg_ch
);

  bscl_pkg::seq_state_t       state_r;
  bscl_pkg::seq_state_t       state_nxt;

  logic [bscl_pkg::CNT_W-1:0] cap_r;
  logic [bscl_pkg::CNT_W-1:0] count_r;
  logic [bscl_pkg::CNT_W-1:0] count_nxt;
  logic [bscl_pkg::CNT_W-1:0] cursor_r;
  logic [bscl_pkg::CNT_W-1:0] cursor_nxt;
  logic [bscl_pkg::CNT_W-1:0] cap_eff;
  logic [bscl_pkg::CNT_W-1:0] count_eff;

  bscl_pkg::op_t              op_r;
  bscl_pkg::op_t              op_nxt;
  bscl_pkg::cmt_t             cmt;
  bscl_pkg::red_t             red;

  bscl_pkg::status_t          status_nxt;
  logic [bscl_pkg::KEY_W-1:0] odist_nxt;
  logic [bscl_pkg::ID_W-1:0]  oid_nxt;
  logic [bscl_pkg::CNT_W-1:0] ins_pos;

  logic                       in_fire;
  logic                       commit_go;
  logic                       out_free;

  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [bscl_pkg::KEY_W-1:0] out_dist_r;
  logic [bscl_pkg::ID_W-1:0]  out_id_r;
  logic                       out_unexp_r;
  logic [bscl_pkg::CNT_W-1:0] out_count_r;

  bscl_pkg::ent_t             ent      [bscl_pkg::LIST_DEPTH];
  bscl_pkg::ent_t             left_ent [bscl_pkg::LIST_DEPTH];
  bscl_pkg::rpt_t             rpt      [bscl_pkg::LIST_DEPTH];

  // ---- capacity ----
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bscl_pkg::CNT_W'(bscl_pkg::CAP_RESET);
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.capacity;
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = bscl_pkg::CNT_W'(1);
    end else if (cap_r > bscl_pkg::CNT_W'(bscl_pkg::LIST_DEPTH)) begin
      cap_eff = bscl_pkg::CNT_W'(bscl_pkg::LIST_DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  // insert first truncates a list left over from a larger capacity
  assign count_eff = (count_r > cap_eff) ? cap_eff : count_r;

  // ---- sequencer ----
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_fire   = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bscl_pkg::SEQ_IDLE: if (in_ch.valid) state_nxt = bscl_pkg::SEQ_CMP;
      bscl_pkg::SEQ_CMP:  state_nxt = bscl_pkg::SEQ_TREE;
      bscl_pkg::SEQ_TREE: state_nxt = bscl_pkg::SEQ_DONE;
      bscl_pkg::SEQ_DONE: if (out_free) state_nxt = bscl_pkg::SEQ_IDLE;
      default:            state_nxt = bscl_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    commit_go   = 1'b0;
    unique case (state_r)
      bscl_pkg::SEQ_IDLE: in_ch.ready = 1'b1;
      bscl_pkg::SEQ_DONE: commit_go   = out_free;
      bscl_pkg::SEQ_CMP,
      bscl_pkg::SEQ_TREE: begin
        in_ch.ready = 1'b0;
        commit_go   = 1'b0;
      end
      default: begin
        in_ch.ready = 1'b0;
        commit_go   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bscl_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- operation latch ----
  always_comb begin
    op_nxt.mode = bscl_pkg::mode_t'(in_ch.mode);
    op_nxt.key  = in_ch.distance;
    op_nxt.node = in_ch.node_id;
    op_nxt.sel_idx = (op_nxt.mode == bscl_pkg::MODE_POP) ? cursor_r
                                                         : {1'b0, in_ch.index};
    op_nxt.lim  = (op_nxt.mode == bscl_pkg::MODE_INSERT) ? count_eff : count_r;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= op_nxt;
    end
  end

  // ---- cell row ----
  for (genvar j = 0; j < bscl_pkg::LIST_DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign left_ent[j] = '0;
    end else begin : g_body
      assign left_ent[j] = ent[j-1];
    end

    bscl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (bscl_pkg::IDX_W'(j)),
      .op_i     (op_r),
      .cmt_i    (cmt),
      .left_i   (left_ent[j]),
      .ent_o    (ent[j]),
      .rpt_o    (rpt[j])
    );
  end

  bscl_tree u_tree (
    .clk   (clk),
    .rpt_i (rpt),
    .red_o (red)
  );

  // ---- commit ----
  assign ins_pos = red.found ? {1'b0, red.first} : count_eff;

  always_comb begin
    status_nxt = bscl_pkg::STAT_OK;
    odist_nxt  = '0;
    oid_nxt    = '0;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    cmt        = '0;
    unique case (op_r.mode)
      bscl_pkg::MODE_CLEAR: begin
        count_nxt  = '0;
        cursor_nxt = '0;
      end
      bscl_pkg::MODE_INSERT: begin
        count_nxt = count_eff;
        priority if ((count_eff == cap_eff) && red.tail) begin
          status_nxt = bscl_pkg::STAT_REJECT;
        end else if (red.dup) begin
          status_nxt = bscl_pkg::STAT_DUP;
        end else begin
          if (ins_pos < cursor_r) cursor_nxt = ins_pos;
          if (ins_pos >= cap_eff) begin
            // lands past the tail of a full list: drop it
            status_nxt = bscl_pkg::STAT_REJECT;
          end else begin
            cmt.ins_en = commit_go;
            cmt.pos    = ins_pos;
            if (count_eff < cap_eff) count_nxt = count_eff + 1'b1;
          end
        end
      end
      bscl_pkg::MODE_POP: begin
        if (cursor_r >= count_r) begin
          status_nxt = bscl_pkg::STAT_EMPTY;
        end else begin
          cmt.pop_en = commit_go;
          cmt.pos    = cursor_r;
          odist_nxt  = red.key;
          oid_nxt    = red.node;
          cursor_nxt = red.found ? {1'b0, red.first} : count_r;
        end
      end
      bscl_pkg::MODE_READ: begin
        if (op_r.sel_idx >= count_r) begin
          status_nxt = bscl_pkg::STAT_EMPTY;
        end else begin
          odist_nxt = red.key;
          oid_nxt   = red.node;
        end
      end
      default: begin
        status_nxt = bscl_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
    end else if (commit_go) begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_status_r <= status_nxt;
      out_dist_r   <= odist_nxt;
      out_id_r     <= oid_nxt;
      out_unexp_r  <= cursor_nxt < count_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.out_distance   = out_dist_r;
  assign out_ch.out_id         = out_id_r;
  assign out_ch.has_unexpanded = out_unexp_r;
  assign out_ch.entry_count    = out_count_r;

endmodule
